>>> hdl/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// tdpc_pkg
// shared widths, constants and controller/datapath types for the trial
// division prime counter
// ----------------------------------------------------------------------------
package tdpc_pkg;

  // width of the tested value, sign bit at the top
  localparam int VALUE_BITS = 32;
  // port widths fixed by the word format
  localparam int FIELD_BITS = 32;
  localparam int COUNT_BITS = 32;
  // trial divisor never passes sqrt(2^(VALUE_BITS-1)) + 1
  localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS    = VALUE_BITS + 1;
  localparam int REM_BITS   = DIV_BITS + 1;
  // magnitude bits shifted through the remainder unit
  localparam int MAG_BITS   = VALUE_BITS - 1;
  localparam int STEP_BITS  = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(MAG_BITS - 1);

  localparam logic [VALUE_BITS-1:0] SMALLEST_PRIME = VALUE_BITS'(2);
  localparam logic [DIV_BITS-1:0]   FIRST_DIVISOR  = DIV_BITS'(2);
  localparam logic [SQ_BITS-1:0]    FIRST_SQUARE   = SQ_BITS'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_TEST,
    ST_DONE
  } tdpc_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new word, restart divisor at two
    logic div_init;   // clear remainder, load magnitude shifter
    logic div_step;   // one restoring remainder step
    logic advance;    // next divisor, next square
    logic set_prime;  // record the verdict
    logic verdict;
    logic finish;     // write result register and running count
  } tdpc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic not_candidate;  // negative, zero or one
    logic past_root;      // divisor squared exceeds the value
    logic last_step;
    logic rem_zero;
    logic out_free;
  } tdpc_stat_t;

endpackage

>>> hdl/tdpc_ctrl.sv
// ----------------------------------------------------------------------------
// tdpc_ctrl
// sequencer for the trial division loop
// ----------------------------------------------------------------------------
module tdpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tdpc_pkg::tdpc_stat_t stat,
  output tdpc_pkg::tdpc_cmd_t  cmd
);

  tdpc_pkg::tdpc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tdpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = tdpc_pkg::ST_CHECK;
        end
      end
      tdpc_pkg::ST_CHECK: begin
        priority if (stat.not_candidate) begin
          cmd.set_prime = 1'b1;
          cmd.verdict   = 1'b0;
          state_nxt     = tdpc_pkg::ST_DONE;
        end else if (stat.past_root) begin
          cmd.set_prime = 1'b1;
          cmd.verdict   = 1'b1;
          state_nxt     = tdpc_pkg::ST_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = tdpc_pkg::ST_DIVIDE;
        end
      end
      tdpc_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.last_step) begin
          state_nxt = tdpc_pkg::ST_TEST;
        end
      end
      tdpc_pkg::ST_TEST: begin
        if (stat.rem_zero) begin
          cmd.set_prime = 1'b1;
          cmd.verdict   = 1'b0;
          state_nxt     = tdpc_pkg::ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = tdpc_pkg::ST_CHECK;
        end
      end
      tdpc_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = tdpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdpc_pkg::ST_IDLE;
      end
    endcase
  end

  // a result is written and the sequencer is back for the next word
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("controller not idle after finish");

  // a new word always starts with a root check
  a_load_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == tdpc_pkg::ST_CHECK)
    else $error("load not followed by check");

  // the remainder unit runs only between init and the last step
  a_step_after_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |=> cmd.div_step)
    else $error("divide did not start after init");

endmodule

>>> hdl/tdpc_datapath.sv
// ----------------------------------------------------------------------------
// tdpc_datapath
// divisor and square registers, bit-serial remainder unit, prime count and
// result register
// ----------------------------------------------------------------------------
module tdpc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [tdpc_pkg::FIELD_BITS-1:0] in_candidate_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tdpc_pkg::FIELD_BITS-1:0] out_tested_value,
  output logic                                 out_is_prime,
  output logic        [tdpc_pkg::COUNT_BITS-1:0] out_primes_so_far,
  input  tdpc_pkg::tdpc_cmd_t                  cmd,
  output tdpc_pkg::tdpc_stat_t                 stat
);

  logic [tdpc_pkg::FIELD_BITS-1:0] echo_r;
  logic [tdpc_pkg::VALUE_BITS-1:0] value_r;
  logic [tdpc_pkg::DIV_BITS-1:0]   div_r;
  logic [tdpc_pkg::SQ_BITS-1:0]    sq_r;
  logic [tdpc_pkg::REM_BITS-1:0]   rem_r;
  logic [tdpc_pkg::MAG_BITS-1:0]   shift_r;
  logic [tdpc_pkg::STEP_BITS-1:0]  step_r;
  logic                            verdict_r;
  logic [tdpc_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                            out_valid_r;
  logic [tdpc_pkg::FIELD_BITS-1:0] out_value_r;
  logic                            out_prime_r;
  logic [tdpc_pkg::COUNT_BITS-1:0] out_count_r;

  logic [tdpc_pkg::REM_BITS-1:0]   rem_sh;
  logic [tdpc_pkg::REM_BITS-1:0]   div_ext;
  logic [tdpc_pkg::SQ_BITS-1:0]    value_ext;

  assign div_ext   = tdpc_pkg::REM_BITS'(div_r);
  assign value_ext = tdpc_pkg::SQ_BITS'(value_r);
  assign rem_sh    = {rem_r[tdpc_pkg::REM_BITS-2:0], shift_r[tdpc_pkg::MAG_BITS-1]};

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      echo_r  <= in_candidate_value;
      value_r <= tdpc_pkg::VALUE_BITS'(unsigned'(in_candidate_value));
      div_r   <= tdpc_pkg::FIRST_DIVISOR;
      sq_r    <= tdpc_pkg::FIRST_SQUARE;
    end else if (cmd.advance) begin
      // (d+1)^2 = d^2 + 2d + 1
      div_r <= div_r + 1'b1;
      sq_r  <= sq_r + tdpc_pkg::SQ_BITS'({div_r, 1'b1});
    end
    if (cmd.div_init) begin
      rem_r   <= '0;
      shift_r <= value_r[tdpc_pkg::MAG_BITS-1:0];
      step_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= (rem_sh >= div_ext) ? rem_sh - div_ext : rem_sh;
      shift_r <= {shift_r[tdpc_pkg::MAG_BITS-2:0], 1'b0};
      step_r  <= step_r + 1'b1;
    end
    if (cmd.set_prime) begin
      verdict_r <= cmd.verdict;
    end
    if (cmd.finish) begin
      out_value_r <= echo_r;
      out_prime_r <= verdict_r;
      out_count_r <= count_nxt;
    end
  end

  // saturating prime count
  always_comb begin
    count_nxt = count_r;
    if (verdict_r && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.not_candidate = value_r[tdpc_pkg::VALUE_BITS-1] ||
                              (value_r < tdpc_pkg::SMALLEST_PRIME);
  assign stat.past_root     = sq_r > value_ext;
  assign stat.last_step     = step_r == tdpc_pkg::LAST_STEP;
  assign stat.rem_zero      = rem_r == '0;
  assign stat.out_free      = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_tested_value  = signed'(out_value_r);
  assign out_is_prime      = out_prime_r;
  assign out_primes_so_far = out_count_r;

  // the incremental square tracks the divisor
  a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> sq_r == tdpc_pkg::SQ_BITS'(div_r) * tdpc_pkg::SQ_BITS'(div_r))
    else $error("square out of step with divisor");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < div_ext)
    else $error("remainder not reduced");

  // the count never goes back
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r >= $past(count_r))
    else $error("prime count decreased");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

endmodule

>>> hdl/trial_division_prime_counter.sv
// sequence: negative, zero and one skip the divisor loop; otherwise each trial
//   divisor takes a root check, the remainder steps over the magnitude bits
//   and a test, until the root is passed or a zero remainder is found
// throughput: one word at a time, set by the one-bit-per-cycle remainder unit
// reset: rst_n synchronous active low, clears the prime count and result valid
// ----------------------------------------------------------------------------
// trial_division_prime_counter
// primality test by trial division with a saturating running prime count
// ----------------------------------------------------------------------------
module trial_division_prime_counter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input word
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tdpc_pkg::FIELD_BITS-1:0] in_candidate_value,
  // result word
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tdpc_pkg::FIELD_BITS-1:0] out_tested_value,
  output logic                                   out_is_prime,
  output logic        [tdpc_pkg::COUNT_BITS-1:0] out_primes_so_far
);

  // command and status between sequencer and datapath
  tdpc_pkg::tdpc_cmd_t  cmd;
  tdpc_pkg::tdpc_stat_t stat;

  // sequencer: accepts a word when idle, walks divisors d = 2, 3, ...
  // while d*d <= value, stops at the first zero remainder
  tdpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: divisor/square registers, restoring remainder unit,
  // saturating count and the result register that decouples out_ready
  tdpc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_candidate_value (in_candidate_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tested_value   (out_tested_value),
    .out_is_prime       (out_is_prime),
    .out_primes_so_far  (out_primes_so_far),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule
